// File: src/addressable_led_strip_driver_macros.svh
// Assertion helpers used by the alsd_dp RTL file.
`ifndef ADDRESSABLE_LED_STRIP_DRIVER_MACROS_SVH
`define ADDRESSABLE_LED_STRIP_DRIVER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ALSD_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ALSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/alsd_pkg.sv
package alsd_pkg;

  localparam int DEF_MAX_LEDS = 16;

  // Line timing in 100 ns ticks.
  localparam logic [3:0] ZERO_HIGH_TICKS = 4'd3;
  localparam logic [3:0] ZERO_LOW_TICKS  = 4'd9;
  localparam logic [3:0] ONE_HIGH_TICKS  = 4'd6;
  localparam logic [3:0] ONE_LOW_TICKS   = 4'd6;
  localparam logic [9:0] LATCH_TICKS     = 10'd800;

  localparam logic [4:0] BITS_PER_LED = 5'd24;

  localparam logic [6:0] BRIGHT_RESET = 7'd60;
  localparam logic [6:0] BRIGHT_MAX   = 7'd100;

  // x / 100 for x below 25600 equals (x * 5243) >> 19.
  localparam logic [12:0] DIV100_RECIP = 13'd5243;
  localparam int          DIV100_SHIFT = 19;

  localparam logic [2:0] OP_SET     = 3'd0;
  localparam logic [2:0] OP_FILL    = 3'd1;
  localparam logic [2:0] OP_REFRESH = 3'd2;
  localparam logic [2:0] OP_CLEAR   = 3'd3;
  localparam logic [2:0] OP_TICK    = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;

  localparam logic REG_COUNT  = 1'b0;
  localparam logic REG_BRIGHT = 1'b1;

  typedef struct packed {
    logic [2:0] opcode;
    logic [3:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } alsd_item_t;

  typedef struct packed {
    logic       line_level;
    logic       busy_res;
    logic       frame_done;
    logic [1:0] status;
  } alsd_result_t;

  typedef struct packed {
    logic       capture;
    logic       walk_clr;
    logic       walk_inc;
    logic       wr_en;
    logic       wr_zero;
    logic       wr_at_idx;
    logic       scale1;
    logic       scale2;
    logic       start_frame;
    logic       tick_step;
    logic       load_word;
    logic       emit;
    logic [1:0] emit_status;
  } alsd_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       refuse;
    logic       idx_bad;
    logic       walk_last;
    logic       sweep_last;
    logic       tick_adv;
  } alsd_stat_t;

  function automatic int addr_width(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

// File: src/alsd_ram.sv
module alsd_ram import alsd_pkg::*; #(
  parameter int WIDTH = 24,
  parameter int DEPTH = DEF_MAX_LEDS
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [addr_width(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]             wdata,
  input  logic [addr_width(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/alsd_ctrl.sv
module alsd_ctrl import alsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  alsd_stat_t stat,
  output alsd_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_DECODE,
    S_SCALE1,
    S_SCALE2,
    S_WRITE,
    S_FETCH,
    S_LOAD
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_SWEEP: begin
        // Zero the whole pixel store once after reset.
        cmd.wr_en    = 1'b1;
        cmd.wr_zero  = 1'b1;
        cmd.walk_inc = 1'b1;
        if (stat.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.capture  = 1'b1;
          cmd.walk_clr = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.op == OP_TICK) begin
          cmd.tick_step   = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_OK;
          state_next      = stat.tick_adv ? S_FETCH : S_IDLE;
        end else if (stat.op > OP_TICK) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_OK;
          state_next      = S_IDLE;
        end else if (stat.refuse) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_REFUSED;
          state_next      = S_IDLE;
        end else begin
          unique case (stat.op)
            OP_SET: begin
              if (stat.idx_bad) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_RANGE;
                state_next      = S_IDLE;
              end else begin
                state_next = S_SCALE1;
              end
            end
            OP_FILL: begin
              state_next = S_SCALE1;
            end
            OP_REFRESH: begin
              cmd.start_frame = 1'b1;
              state_next      = S_FETCH;
            end
            OP_CLEAR: begin
              state_next = S_WRITE;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_SCALE1: begin
        cmd.scale1 = 1'b1;
        state_next = S_SCALE2;
      end
      S_SCALE2: begin
        cmd.scale2 = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.wr_en     = 1'b1;
        cmd.wr_zero   = (stat.op == OP_CLEAR);
        cmd.wr_at_idx = (stat.op == OP_SET);
        if ((stat.op == OP_SET) || stat.walk_last) begin
          if (stat.op == OP_CLEAR) begin
            cmd.start_frame = 1'b1;
            state_next      = S_FETCH;
          end else begin
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_OK;
            state_next      = S_IDLE;
          end
        end else begin
          cmd.walk_inc = 1'b1;
        end
      end
      S_FETCH: begin
        // The store read of the current LED lands at the end of this cycle.
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_word = 1'b1;
        if (stat.op != OP_TICK) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_OK;
        end
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
      busy  <= 1'b1;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

// File: src/alsd_dp.sv
`include "addressable_led_strip_driver_macros.svh"

module alsd_dp import alsd_pkg::*; #(
  parameter int MAX_LEDS = DEF_MAX_LEDS
) (
  input  logic         clk,
  input  logic         rst,
  input  alsd_item_t   item,
  input  alsd_cmd_t    cmd,
  output alsd_stat_t   stat,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output alsd_result_t res,
  output logic         res_valid
);

  localparam int AW = addr_width(MAX_LEDS);

  logic [4:0]  active_led_count;
  logic [6:0]  brightness_percent;
  alsd_item_t  item_q;

  logic [14:0] prod_r, prod_g, prod_b;
  logic [23:0] scaled;
  logic [AW-1:0] walk;

  logic [23:0]   cur_word;
  logic          sending;
  logic [AW-1:0] led_cursor;
  logic [4:0]    bit_cursor;
  logic          in_high_phase;
  logic [3:0]    phase_count;
  logic [9:0]    latch_count;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [23:0]   ram_wdata;
  logic [23:0]   ram_rdata;

  logic       cfg_wr;
  logic [6:0] bright_in;
  logic       ready;

  // Next serializer state and outputs for one tick.
  logic          t_sending, t_high, t_line, t_busy, t_done, t_adv;
  logic [AW-1:0] t_led;
  logic [4:0]    t_bit;
  logic [3:0]    t_phase;
  logic [9:0]    t_latch;
  logic          cur_bit, led_last;
  logic [3:0]    hi_ticks, lo_ticks, phase_inc;
  logic [4:0]    bit_inc;
  logic [9:0]    latch_inc;

  logic [27:0] quo_r, quo_g, quo_b;

  // Configuration registers.
  assign cfg_wr    = psel && penable && pwrite;
  assign bright_in = (pwdata[6:0] > BRIGHT_MAX) ? BRIGHT_MAX : pwdata[6:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      active_led_count   <= '0;
      brightness_percent <= BRIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_COUNT: begin
          // The frame length stays fixed while a frame is on the line.
          if (!sending) begin
            active_led_count <= pwdata[4:0];
          end
        end
        REG_BRIGHT: begin
          brightness_percent <= bright_in;
        end
        default: begin
        end
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_BRIGHT) ? {25'd0, brightness_percent}
                                           : {27'd0, active_led_count};

  assign ready = (active_led_count != '0) && (int'(active_led_count) <= MAX_LEDS);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_q <= item;
    end
  end

  // Brightness scaling in two stages: product, then divide by 100.
  assign quo_r = 28'(prod_r) * 28'(DIV100_RECIP);
  assign quo_g = 28'(prod_g) * 28'(DIV100_RECIP);
  assign quo_b = 28'(prod_b) * 28'(DIV100_RECIP);

  always_ff @(posedge clk) begin
    if (cmd.scale1) begin
      prod_r <= 15'(item_q.red)   * 15'(brightness_percent);
      prod_g <= 15'(item_q.green) * 15'(brightness_percent);
      prod_b <= 15'(item_q.blue)  * 15'(brightness_percent);
    end
    if (cmd.scale2) begin
      scaled <= {quo_g[DIV100_SHIFT +: 8], quo_r[DIV100_SHIFT +: 8],
                 quo_b[DIV100_SHIFT +: 8]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk <= '0;
    end else if (cmd.walk_clr) begin
      walk <= '0;
    end else if (cmd.walk_inc) begin
      walk <= walk + AW'(1);
    end
  end

  assign ram_we    = cmd.wr_en;
  assign ram_waddr = cmd.wr_at_idx ? AW'(item_q.pixel_index) : walk;
  assign ram_wdata = cmd.wr_zero ? 24'd0 : scaled;

  alsd_ram #(
    .WIDTH (24),
    .DEPTH (MAX_LEDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (led_cursor),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_word) begin
      cur_word <= ram_rdata;
    end
  end

  // One tick of the serial line.
  assign cur_bit   = cur_word[5'(BITS_PER_LED - 5'd1 - bit_cursor)];
  assign hi_ticks  = cur_bit ? ONE_HIGH_TICKS : ZERO_HIGH_TICKS;
  assign lo_ticks  = cur_bit ? ONE_LOW_TICKS : ZERO_LOW_TICKS;
  assign phase_inc = phase_count + 4'd1;
  assign bit_inc   = bit_cursor + 5'd1;
  assign latch_inc = latch_count + 10'd1;
  assign led_last  = (int'(led_cursor) + 1) >= int'(active_led_count);

  always_comb begin
    t_sending = sending;
    t_led     = led_cursor;
    t_bit     = bit_cursor;
    t_high    = in_high_phase;
    t_phase   = phase_count;
    t_latch   = latch_count;
    t_line    = 1'b0;
    t_busy    = 1'b0;
    t_done    = 1'b0;
    t_adv     = 1'b0;
    if (sending) begin
      t_busy = 1'b1;
      if (bit_cursor >= BITS_PER_LED) begin
        t_latch = latch_inc;
        if (latch_inc >= LATCH_TICKS) begin
          t_done    = 1'b1;
          t_sending = 1'b0;
          t_led     = '0;
          t_bit     = '0;
          t_high    = 1'b0;
          t_phase   = '0;
          t_latch   = '0;
        end
      end else begin
        t_phase = phase_inc;
        if (in_high_phase) begin
          t_line = 1'b1;
          if (phase_inc >= hi_ticks) begin
            t_phase = '0;
            t_high  = 1'b0;
          end
        end else if (phase_inc >= lo_ticks) begin
          t_phase = '0;
          if (bit_inc >= BITS_PER_LED) begin
            if (led_last) begin
              t_bit   = BITS_PER_LED;
              t_high  = 1'b0;
              t_latch = '0;
            end else begin
              // Next LED: its word has to be read from the store first.
              t_led  = led_cursor + AW'(1);
              t_bit  = '0;
              t_high = 1'b1;
              t_adv  = 1'b1;
            end
          end else begin
            t_bit  = bit_inc;
            t_high = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sending       <= 1'b0;
      led_cursor    <= '0;
      bit_cursor    <= '0;
      in_high_phase <= 1'b0;
      phase_count   <= '0;
      latch_count   <= '0;
    end else if (cmd.start_frame) begin
      sending       <= 1'b1;
      led_cursor    <= '0;
      bit_cursor    <= '0;
      in_high_phase <= 1'b1;
      phase_count   <= '0;
      latch_count   <= '0;
    end else if (cmd.tick_step) begin
      sending       <= t_sending;
      led_cursor    <= t_led;
      bit_cursor    <= t_bit;
      in_high_phase <= t_high;
      phase_count   <= t_phase;
      latch_count   <= t_latch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (cmd.tick_step) begin
        res <= '{line_level: t_line, busy_res: t_busy, frame_done: t_done,
                 status: ST_OK};
      end else begin
        res <= '{line_level: 1'b0, busy_res: sending, frame_done: 1'b0,
                 status: cmd.emit_status};
      end
    end
  end

  assign stat.op         = item_q.opcode;
  assign stat.refuse     = !ready || sending;
  assign stat.idx_bad    = {1'b0, item_q.pixel_index} >= active_led_count;
  assign stat.walk_last  = int'(walk) == (int'(active_led_count) - 1);
  assign stat.sweep_last = int'(walk) == (MAX_LEDS - 1);
  assign stat.tick_adv   = t_adv;

  `ALSD_ASSERT(a_cursor_in_chain, sending,
      int'(led_cursor) < int'(active_led_count),
      "LED cursor left the active chain during a frame")
  `ALSD_ASSERT(a_idle_clean, !sending,
      (bit_cursor == '0) && (latch_count == '0) && !in_high_phase && (phase_count == '0),
      "Serializer counters not cleared while no frame is sending")
  `ALSD_ASSERT(a_latch_low, sending && (bit_cursor == BITS_PER_LED),
      !in_high_phase && (phase_count == '0),
      "Line phase active during the latch period")
  `ALSD_ASSERT(a_done_on_tick, res_valid && res.frame_done,
      res.busy_res && (res.status == ST_OK) && !res.line_level,
      "Frame end reported with inconsistent result fields")
  `ALSD_ASSERT_NEXT(a_frame_start, cmd.start_frame,
      sending && in_high_phase && (led_cursor == '0) && (bit_cursor == '0),
      "Frame did not start at the first bit of the first LED")

endmodule

// File: src/addressable_led_strip_driver.sv
// Channel   Ports                                    Handshake
// item in   item (alsd_item_t)                       start && !busy
// result    res (alsd_result_t)                      res_valid, one cycle
// config    psel penable pwrite paddr pwdata prdata  APB, pready tied high
//
// A tick, unknown code, refused command or out-of-range index gives its result
// from decode; a tick to the next LED keeps busy through fetch and load to read
// its word. Set runs decode, scale1, scale2, write; fill writes every active
// LED; refresh starts a frame via fetch and load; clear zeroes every active LED,
// then starts a frame. After reset busy stays high while the store is zeroed,
// one entry a cycle. Results cannot be stalled; each is shown for one cycle.
module addressable_led_strip_driver import alsd_pkg::*; #(
  parameter int MAX_LEDS = DEF_MAX_LEDS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  alsd_item_t   item,
  output logic         res_valid,
  output alsd_result_t res,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  alsd_cmd_t  cmd;
  alsd_stat_t stat;

  assign pready = 1'b1;

  alsd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  alsd_dp #(
    .MAX_LEDS (MAX_LEDS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd       (cmd),
    .stat      (stat),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .res       (res),
    .res_valid (res_valid)
  );

endmodule
